@@ hw/rtl/tccw_pkg.sv @@
package tccw_pkg;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS    = 7'd25;
    localparam logic [7:0] RST_ATTR    = 8'd7;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_ATTR    = 2'd2;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [2:0] TAB_STEP = 3'd4;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SC_INIT,
        ST_SC_DLEN,
        ST_SC_LEN,
        ST_SC_SLEN,
        ST_SC_RD,
        ST_SC_WR,
        ST_SC_BOT,
        ST_OUT,
        ST_HOLD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write zero at the clear pointer and advance it
        logic load_item;  // capture the accepted beat
        logic exec;       // run the cursor update of a put
        logic rd_issue;   // read the cell of a read command
        logic sc_start;   // begin a scroll at destination row 0
        logic sc_init;    // read the length of row 0
        logic sc_dlen;    // take the length of row 0 as the destination length
        logic sc_len;     // read the length of the source row
        logic sc_slen;    // take the source row length
        logic sc_rd;      // read the source cell at the column pointer
        logic sc_wr;      // write the copied or blanked cell, step the column
        logic sc_next;    // finish the row pair and move down one row
        logic sc_bot;     // blank one bottom row cell
        logic sc_end;     // clear the bottom row length
        logic out_load;   // load the result register
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic need_scroll;
        logic sc_row_last;  // destination is the bottom row
        logic sc_col_done;  // column pointer reached the end of the row pair
        logic bot_done;
    } sts_t;

endpackage

@@ hw/rtl/tccw_ctrl.sv @@
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_read)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next = ST_RDWAIT;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    if (sts.need_scroll)
                    begin
                        cmd.sc_start = 1'b1;
                        state_next = ST_SC_INIT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_OUT;
            end
            ST_SC_INIT:
            begin
                cmd.sc_init = 1'b1;
                state_next = ST_SC_DLEN;
            end
            ST_SC_DLEN:
            begin
                cmd.sc_dlen = 1'b1;
                state_next = ST_SC_LEN;
            end
            ST_SC_LEN:
            begin
                if (sts.sc_row_last)
                begin
                    state_next = ST_SC_BOT;
                end
                else
                begin
                    cmd.sc_len = 1'b1;
                    state_next = ST_SC_SLEN;
                end
            end
            ST_SC_SLEN:
            begin
                cmd.sc_slen = 1'b1;
                state_next = ST_SC_RD;
            end
            ST_SC_RD:
            begin
                if (sts.sc_col_done)
                begin
                    cmd.sc_next = 1'b1;
                    state_next = ST_SC_LEN;
                end
                else
                begin
                    cmd.sc_rd = 1'b1;
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR:
            begin
                cmd.sc_wr = 1'b1;
                state_next = ST_SC_RD;
            end
            ST_SC_BOT:
            begin
                if (sts.bot_done)
                begin
                    cmd.sc_end = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.sc_bot = 1'b1;
                end
            end
            ST_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
                in_ready = 1'b0;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tccw_dp.sv @@
module tccw_dp
    import tccw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [7:0]  cfg_data,
    input  logic [23:0] in_tdata,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [47:0] res_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = CW + RW;
    localparam int LW = CW + 1;
    localparam int RCW = RW + 1;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;

    logic [7:0] columns_reg;
    logic [6:0] rows_reg;
    logic [7:0] attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= RST_COLUMNS;
            rows_reg <= RST_ROWS;
            attr_reg <= RST_ATTR;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_COLUMNS: columns_reg <= cfg_data;
                REG_ROWS:    rows_reg <= cfg_data[6:0];
                REG_ATTR:    attr_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Saturated geometry. A count of zero is taken as one, and a count above the
    // maximum is taken as the maximum.
    logic [LW-1:0]  cols;
    logic [RCW-1:0] rows;
    always_comb
    begin
        if (columns_reg == 8'd0)
            cols = LW'(1);
        else if (32'(columns_reg) > MAX_COLS)
            cols = LW'(MAX_COLS);
        else
            cols = LW'(columns_reg);
        if (rows_reg == 7'd0)
            rows = RCW'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            rows = RCW'(MAX_ROWS);
        else
            rows = RCW'(rows_reg);
    end

    logic [15:0] mem [DEPTH];
    logic [LW-1:0] len_mem [MAX_ROWS];
    logic [15:0] rdata_reg;
    logic [LW-1:0] len_rd_reg;
    logic [47:0] res_reg;

    logic        cmd_reg;
    logic [7:0]  code_reg;
    logic [6:0]  rcol_reg;
    logic [5:0]  rrow_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW:0]   clr_reg;
    logic [RW-1:0] sc_dst_reg;
    logic [LW-1:0] sc_ptr_reg;
    logic [LW-1:0] slen_reg, dlen_reg;
    logic          rd_valid_reg;

    // Put cursor logic, combinational.
    logic [LW-1:0]  c0, ncol, room;
    logic [RCW-1:0] r0, nrow;
    logic           do_wr, do_len;
    logic [7:0]     drawn;
    always_comb
    begin
        c0 = (LW'(col_reg) >= cols) ? cols - LW'(1) : LW'(col_reg);
        r0 = (RCW'(row_reg) >= rows) ? rows - RCW'(1) : RCW'(row_reg);
        ncol = c0;
        nrow = r0;
        do_wr = 1'b0;
        do_len = 1'b0;
        room = cols - c0;
        drawn = (code_reg < CH_SPACE || code_reg > CH_TILDE) ? CH_SPACE : code_reg;
        if (code_reg == CH_CR || code_reg == CH_LF)
        begin
            ncol = '0;
            if (code_reg == CH_LF)
                nrow = r0 + RCW'(1);
        end
        else if (code_reg == CH_BS && c0 != '0)
        begin
            ncol = c0 - LW'(1);
        end
        else
        begin
            do_len = 1'b1;
            if (code_reg == CH_TAB)
                ncol = c0 + ((room < LW'(TAB_STEP)) ? room : LW'(TAB_STEP));
            else
            begin
                do_wr = 1'b1;
                ncol = c0 + LW'(1);
            end
        end
    end
    logic wrap;
    assign wrap = do_len && (ncol == cols);

    // A stored row length beyond the columns in use counts as the full row.
    logic [LW-1:0] len_used;
    assign len_used = (len_rd_reg > cols) ? cols : len_rd_reg;
    logic [LW-1:0] span;
    assign span = (slen_reg > dlen_reg) ? slen_reg : dlen_reg;
    logic [RW-1:0] bot;
    assign bot = RW'(rows - RCW'(1));

    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;
    logic          we, re;
    always_comb
    begin
        we = 1'b0;
        re = 1'b0;
        waddr = '0;
        raddr = '0;
        wdata = '0;
        if (cmd.clr_step)
        begin
            we = !clr_reg[AW];
            waddr = clr_reg[AW-1:0];
        end
        else if (cmd.exec && do_wr)
        begin
            we = 1'b1;
            waddr = {RW'(r0), CW'(c0)};
            wdata = {attr_reg, drawn};
        end
        else if (cmd.sc_wr)
        begin
            we = 1'b1;
            waddr = {sc_dst_reg, CW'(sc_ptr_reg)};
            wdata = (sc_ptr_reg < slen_reg) ? rdata_reg : {attr_reg, CH_SPACE};
        end
        else if (cmd.sc_bot)
        begin
            we = 1'b1;
            waddr = {bot, CW'(sc_ptr_reg)};
            wdata = {attr_reg, CH_SPACE};
        end
        if (cmd.rd_issue)
        begin
            re = 1'b1;
            raddr = {RW'(rrow_reg), CW'(rcol_reg)};
        end
        else if (cmd.sc_rd)
        begin
            re = 1'b1;
            raddr = {RW'(sc_dst_reg + RW'(1)), CW'(sc_ptr_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Row length store: one write and one registered read per cycle. The
    // clearing pass after reset also zeroes every row length.
    logic [RW-1:0] lwaddr, lraddr;
    logic [LW-1:0] lwdata;
    logic          lwe, lre;
    always_comb
    begin
        lwe = 1'b0;
        lre = 1'b0;
        lwaddr = '0;
        lraddr = '0;
        lwdata = '0;
        if (cmd.clr_step)
        begin
            lwe = !clr_reg[AW];
            lwaddr = clr_reg[RW-1:0];
        end
        else if (cmd.exec && do_len)
        begin
            lwe = 1'b1;
            lwaddr = RW'(r0);
            lwdata = ncol;
        end
        else if (cmd.sc_next)
        begin
            lwe = 1'b1;
            lwaddr = sc_dst_reg;
            lwdata = slen_reg;
        end
        else if (cmd.sc_end)
        begin
            lwe = 1'b1;
            lwaddr = bot;
        end
        if (cmd.sc_init)
        begin
            lre = 1'b1;
            lraddr = '0;
        end
        else if (cmd.sc_len)
        begin
            lre = 1'b1;
            lraddr = sc_dst_reg + RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (lwe)
            len_mem[lwaddr] <= lwdata;
        if (lre)
            len_rd_reg <= len_mem[lraddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step && !clr_reg[AW])
                clr_reg <= clr_reg + (AW+1)'(1);
            if (cmd.exec)
            begin
                col_reg <= wrap ? '0 : CW'(ncol);
                row_reg <= sts.need_scroll ? bot : RW'(wrap ? r0 + RCW'(1) : nrow);
            end
            if (cmd.load_item)
                rd_valid_reg <= 1'b0;
            if (cmd.rd_issue)
                rd_valid_reg <= 1'b1;
        end
    end

    logic [RW+LW-1:0] linear;
    assign linear = (RW+LW)'(row_reg) * (RW+LW)'(cols) + (RW+LW)'(col_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg <= in_tdata[0];
            code_reg <= in_tdata[8:1];
            rcol_reg <= in_tdata[15:9];
            rrow_reg <= in_tdata[21:16];
        end
        if (cmd.sc_start)
        begin
            sc_dst_reg <= '0;
            sc_ptr_reg <= '0;
        end
        if (cmd.sc_dlen)
            dlen_reg <= len_used;
        if (cmd.sc_slen)
            slen_reg <= len_used;
        if (cmd.sc_wr || cmd.sc_bot)
            sc_ptr_reg <= sc_ptr_reg + LW'(1);
        if (cmd.sc_next)
        begin
            // The source row becomes the next destination, so its length carries over.
            sc_dst_reg <= sc_dst_reg + RW'(1);
            sc_ptr_reg <= '0;
            dlen_reg <= slen_reg;
        end
        if (cmd.out_load)
        begin
            res_reg <= {6'd0,
                        (cmd_reg == CMD_READ && rd_valid_reg) ? rdata_reg : 16'h0,
                        13'(linear), 6'(row_reg), 7'(col_reg)};
        end
    end

    assign res_data = res_reg;

    always_comb
    begin
        sts.clr_done = clr_reg[AW];
        sts.is_read = (cmd_reg == CMD_READ);
        sts.need_scroll = (wrap ? r0 + RCW'(1) : nrow) >= rows;
        sts.sc_row_last = (RCW'(sc_dst_reg) + RCW'(1) >= rows);
        sts.sc_col_done = (sc_ptr_reg >= span);
        sts.bot_done = (sc_ptr_reg >= dlen_reg);
    end

endmodule

@@ hw/rtl/text_console_cell_writer.sv @@
// Channel | Group | Fields (low bit up)
// input   | s_    | tdata: cmd, char_code, read_col, read_row
// output  | m_    | tdata: cursor_col, cursor_row, cursor_linear, cell_char, cell_attr
// config  | cfg_  | 0 columns, 1 rows_in_use, 2 text_attr
// A put steps through exec, output load and hold; a read adds a wait for the cell read.
// Input is taken again from the cycle after the output beat is accepted.
// A scroll reads the row lengths, then copies each row pair cell by cell, a read and then
// a write per cell, set by the single read port of the cell store, then blanks the bottom row.
// After reset a clearing pass zeroes every cell and row length before input is taken.
// One item is in flight; input waits while a result is held.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // cmd, char_code, read_col, read_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // cursor_col, cursor_row, cursor_linear, cell_char, cell_attr
);

    cmd_t cmd;
    sts_t sts;

    tccw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .cmd(cmd)
    );

    tccw_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .in_tdata(s_tdata), .cmd(cmd), .sts(sts),
        .res_data(m_tdata)
    );

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("ready while result held");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

endmodule
